// ===== rtl/core/bhp_pkg.sv =====
// Package: types and constants shared by the BMP header and pixel parser.
`timescale 1ns / 1ps
package bhp_pkg;

  localparam int ROWCOL_W    = 13;
  localparam int OUT_TDATA_W = 152;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEADER,
    PH_SKIP,
    PH_PIXEL,
    PH_DONE,
    PH_ERROR
  } bhp_phase_t;

  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  localparam logic [1:0] ST_PIXEL      = 2'd0;
  localparam logic [1:0] ST_HEADER     = 2'd1;
  localparam logic [1:0] ST_FORMAT_ERR = 2'd2;
  localparam logic [1:0] ST_TRUNC      = 2'd3;

  // header byte positions that complete a field
  localparam logic [31:0] POS_SIG      = 32'd1;
  localparam logic [31:0] POS_OFFSET   = 32'd13;
  localparam logic [31:0] POS_INFO     = 32'd17;
  localparam logic [31:0] POS_WIDTH    = 32'd21;
  localparam logic [31:0] POS_HEIGHT   = 32'd25;
  localparam logic [31:0] POS_PLANES   = 32'd27;
  localparam logic [31:0] POS_BPP      = 32'd29;
  localparam logic [31:0] POS_COMP     = 32'd33;
  localparam logic [31:0] POS_LAST     = 32'd53;
  localparam logic [31:0] HEADER_BYTES = 32'd54;

  localparam logic [15:0] SIG_BM        = 16'h4D42;
  localparam logic [31:0] INFO_SIZE     = 32'd40;
  localparam logic [15:0] PLANES_ONE    = 16'd1;
  localparam logic [15:0] BPP_24        = 16'd24;
  localparam logic [31:0] COMP_NONE     = 32'd0;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
  } bhp_item_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [7:0]          red;
    logic [7:0]          green;
    logic [7:0]          blue;
    logic [ROWCOL_W-1:0] row;
    logic [ROWCOL_W-1:0] col;
    logic                last_pixel;
    logic [31:0]         width;
    logic [31:0]         height;
    logic [31:0]         pixel_offset;
  } bhp_res_t;

endpackage

// ===== rtl/core/bmp_header_and_pixel_parser_top.sv =====
// Top level of the streaming 24-bit BMP header and pixel parser.
//
// Input stream: one transfer per file byte. in_tuser carries the kind
// (data byte, start of file, end of stream), in_tdata the byte.
// Result stream: out_tuser is the status (pixel, header accepted, format
// error, truncated); out_tdata packs the pixel colour, row and column, and
// the header width, height and pixel offset; out_tlast marks the final
// pixel of the image. Fields a status does not use read as zero.
// Each input transfer gives at most one result transfer.
// A result passes from the input register through the single-pass parser
// into the result register before it is offered on the result port.
// Throughput: one byte per cycle while the result receiver accepts, set by
// the single-pass parser between the two registers; pixel offset skipping
// and row padding run at the same rate.
// Reset (rst_n low, synchronous) empties both registers and returns the
// parser to idle; a start-of-file transfer is needed before any data.
// A stalled receiver holds the result register; a byte already in the
// input register waits there, and in_tready drops until space frees.
`timescale 1ns / 1ps
module bmp_header_and_pixel_parser_top
  import bhp_pkg::*;
#(
  parameter int MAX_DIM = 8192
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [7:0]             in_tdata,   // [7:0] data_byte
  input  logic [1:0]             in_tuser,   // [1:0] kind
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [7:0] red, [15:8] green, [23:16] blue, [36:24] row, [49:37] col,
  // [81:50] width, [113:82] height, [145:114] pixel_offset, rest zero
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic [1:0]             out_tuser,  // [1:0] status
  output logic                   out_tlast
);

  logic      item_valid;
  bhp_item_t item;
  logic      up_ready;
  logic      res_valid;
  bhp_res_t  res;

  bhp_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .take       (up_ready),
    .item_valid (item_valid),
    .item       (item)
  );

  bhp_parser #(
    .MAX_DIM (MAX_DIM)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .down_ready (up_ready),
    .res_valid  (res_valid),
    .res        (res)
  );

  bhp_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res_valid),
    .res        (res),
    .up_ready   (up_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== rtl/core/bhp_in_stage.sv =====
// Input register stage holding one accepted byte transfer.
`timescale 1ns / 1ps
module bhp_in_stage
  import bhp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  logic [7:0] in_tdata,  // [7:0] data_byte
  input  logic [1:0] in_tuser,  // [1:0] kind
  input  logic      take,
  output logic      item_valid,
  output bhp_item_t item
);

  logic      valid_r;
  logic      valid_nxt;
  bhp_item_t item_r;

  assign in_tready  = !valid_r || take;
  assign valid_nxt  = in_tready ? in_tvalid : valid_r;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r.kind <= in_tuser;
      item_r.data <= in_tdata;
    end
  end

endmodule

// ===== rtl/core/bhp_parser.sv =====
// Parser state machine, header field checks and pixel assembly.
`timescale 1ns / 1ps
module bhp_parser
  import bhp_pkg::*;
#(
  parameter int MAX_DIM = 8192
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      item_valid,
  input  bhp_item_t item,
  input  logic      down_ready,
  output logic      res_valid,
  output bhp_res_t  res
);

  localparam int DIM_W   = $clog2(MAX_DIM + 1);
  localparam int PITCH_W = DIM_W + 2;

  bhp_phase_t       phase_r, phase_nxt;
  logic [31:0]      byte_count_r, byte_count_nxt;
  logic [31:0]      field_shift_r, field_shift_nxt;
  logic [31:0]      saved_width_r, saved_width_nxt;
  logic [31:0]      saved_height_r, saved_height_nxt;
  logic [31:0]      saved_offset_r, saved_offset_nxt;
  logic [31:0]      row_start_r, row_start_nxt;
  logic [DIM_W-1:0] row_cnt_r, row_cnt_nxt;
  logic [DIM_W-1:0] col_cnt_r, col_cnt_nxt;
  logic [DIM_W-1:0] cols_r, cols_nxt;
  logic [DIM_W-1:0] rows_r, rows_nxt;
  logic [1:0]       chan_r, chan_nxt;
  logic [7:0]       held_blue_r, held_blue_nxt;
  logic [7:0]       held_green_r, held_green_nxt;

  logic               act;
  logic [31:0]        fs_shift;
  logic [31:0]        bc_inc;
  logic [31:0]        mag_w;
  logic [31:0]        mag_h;
  logic               hdr_bad;
  logic               hdr_end;
  logic [DIM_W-1:0]   col_inc;
  logic [DIM_W-1:0]   row_inc;
  logic               col_wrap;
  logic               row_wrap;
  logic [PITCH_W-1:0] cols3;
  logic [PITCH_W-1:0] pitch;
  logic [31:0]        new_target;
  logic               pix_emit;
  logic               trunc;

  assign act        = item_valid && down_ready;
  assign fs_shift   = {item.data, field_shift_r[31:8]};
  assign bc_inc     = byte_count_r + 32'd1;
  assign mag_w      = saved_width_r[31] ? (~saved_width_r + 32'd1) : saved_width_r;
  assign mag_h      = saved_height_r[31] ? (~saved_height_r + 32'd1) : saved_height_r;
  assign col_inc    = col_cnt_r + DIM_W'(1);
  assign row_inc    = row_cnt_r + DIM_W'(1);
  assign col_wrap   = (col_inc == cols_r);
  assign row_wrap   = (row_inc == rows_r);
  assign cols3      = ({2'b00, cols_r} << 1) + {2'b00, cols_r} + PITCH_W'(3);
  assign pitch      = cols3 & ~PITCH_W'(3);
  assign new_target = row_start_r + 32'(pitch);
  assign pix_emit   = (phase_r == PH_PIXEL) && (chan_r == 2'd2);
  assign trunc      = (phase_r == PH_HEADER) || (phase_r == PH_SKIP) || (phase_r == PH_PIXEL);

  always_comb begin
    case (byte_count_r)
      POS_SIG:    hdr_bad = (fs_shift[31:16] != SIG_BM);
      POS_INFO:   hdr_bad = (fs_shift != INFO_SIZE);
      POS_PLANES: hdr_bad = (fs_shift[31:16] != PLANES_ONE);
      POS_BPP:    hdr_bad = (fs_shift[31:16] != BPP_24);
      POS_COMP:   hdr_bad = (fs_shift != COMP_NONE);
      POS_LAST:   hdr_bad = (mag_w > 32'(MAX_DIM)) || (mag_h > 32'(MAX_DIM)) ||
                            ((mag_h != 32'd0) && (saved_offset_r < HEADER_BYTES));
      default:    hdr_bad = 1'b0;
    endcase
    hdr_end = (byte_count_r == POS_LAST) && !hdr_bad;
  end

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (act) begin
      case (item.kind)
        KIND_START: phase_nxt = PH_HEADER;
        KIND_END: begin
          if (trunc) phase_nxt = PH_IDLE;
        end
        KIND_DATA: begin
          case (phase_r)
            PH_HEADER: begin
              if (hdr_bad) begin
                phase_nxt = PH_ERROR;
              end else if (hdr_end) begin
                if (mag_h == 32'd0) phase_nxt = PH_DONE;
                else if (bc_inc != saved_offset_r) phase_nxt = PH_SKIP;
                else if (mag_w == 32'd0) phase_nxt = PH_DONE;
                else phase_nxt = PH_PIXEL;
              end
            end
            PH_SKIP: begin
              if (bc_inc == row_start_r) begin
                phase_nxt = (cols_r == '0) ? PH_DONE : PH_PIXEL;
              end
            end
            PH_PIXEL: begin
              if (chan_r == 2'd2 && col_wrap) begin
                if (row_wrap) phase_nxt = PH_DONE;
                else if (bc_inc != new_target) phase_nxt = PH_SKIP;
                else if (cols_r == '0) phase_nxt = PH_DONE;
                else phase_nxt = PH_PIXEL;
              end
            end
            default: phase_nxt = phase_r;
          endcase
        end
        default: phase_nxt = phase_r;
      endcase
    end
  end

  // datapath next values
  always_comb begin
    byte_count_nxt   = byte_count_r;
    field_shift_nxt  = field_shift_r;
    saved_width_nxt  = saved_width_r;
    saved_height_nxt = saved_height_r;
    saved_offset_nxt = saved_offset_r;
    row_start_nxt    = row_start_r;
    row_cnt_nxt      = row_cnt_r;
    col_cnt_nxt      = col_cnt_r;
    cols_nxt         = cols_r;
    rows_nxt         = rows_r;
    chan_nxt         = chan_r;
    held_blue_nxt    = held_blue_r;
    held_green_nxt   = held_green_r;
    if (act && item.kind == KIND_START) begin
      byte_count_nxt   = '0;
      field_shift_nxt  = '0;
      saved_width_nxt  = '0;
      saved_height_nxt = '0;
      saved_offset_nxt = '0;
      row_start_nxt    = '0;
      row_cnt_nxt      = '0;
      col_cnt_nxt      = '0;
      cols_nxt         = '0;
      rows_nxt         = '0;
      chan_nxt         = '0;
      held_blue_nxt    = '0;
      held_green_nxt   = '0;
    end else if (act && item.kind == KIND_DATA) begin
      case (phase_r)
        PH_HEADER: begin
          byte_count_nxt  = bc_inc;
          field_shift_nxt = fs_shift;
          if (byte_count_r == POS_OFFSET) saved_offset_nxt = fs_shift;
          if (byte_count_r == POS_WIDTH)  saved_width_nxt  = fs_shift;
          if (byte_count_r == POS_HEIGHT) saved_height_nxt = fs_shift;
          if (hdr_end) begin
            row_cnt_nxt = '0;
            col_cnt_nxt = '0;
            chan_nxt    = '0;
            cols_nxt    = DIM_W'(mag_w);
            rows_nxt    = DIM_W'(mag_h);
            if (mag_h != 32'd0) row_start_nxt = saved_offset_r;
          end
        end
        PH_SKIP: byte_count_nxt = bc_inc;
        PH_PIXEL: begin
          byte_count_nxt = bc_inc;
          case (chan_r)
            2'd0: begin
              held_blue_nxt = item.data;
              chan_nxt      = 2'd1;
            end
            2'd1: begin
              held_green_nxt = item.data;
              chan_nxt       = 2'd2;
            end
            default: begin
              chan_nxt = 2'd0;
              if (col_wrap) begin
                col_cnt_nxt = '0;
                row_cnt_nxt = row_inc;
                if (!row_wrap) row_start_nxt = new_target;
              end else begin
                col_cnt_nxt = col_inc;
              end
            end
          endcase
        end
        default: byte_count_nxt = byte_count_r;
      endcase
    end
  end

  // result
  always_comb begin
    res       = '0;
    res_valid = 1'b0;
    if (act && item.kind == KIND_END && trunc) begin
      res_valid  = 1'b1;
      res.status = ST_TRUNC;
    end else if (act && item.kind == KIND_DATA) begin
      if (phase_r == PH_HEADER && hdr_bad) begin
        res_valid  = 1'b1;
        res.status = ST_FORMAT_ERR;
      end else if (phase_r == PH_HEADER && hdr_end) begin
        res_valid        = 1'b1;
        res.status       = ST_HEADER;
        res.width        = saved_width_r;
        res.height       = saved_height_r;
        res.pixel_offset = saved_offset_r;
      end else if (pix_emit) begin
        res_valid      = 1'b1;
        res.status     = ST_PIXEL;
        res.red        = item.data;
        res.green      = held_green_r;
        res.blue       = held_blue_r;
        res.row        = ROWCOL_W'(row_cnt_r);
        res.col        = ROWCOL_W'(col_cnt_r);
        res.last_pixel = row_wrap && col_wrap;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_IDLE;
      byte_count_r   <= '0;
      field_shift_r  <= '0;
      saved_width_r  <= '0;
      saved_height_r <= '0;
      saved_offset_r <= '0;
      row_start_r    <= '0;
      row_cnt_r      <= '0;
      col_cnt_r      <= '0;
      cols_r         <= '0;
      rows_r         <= '0;
      chan_r         <= '0;
      held_blue_r    <= '0;
      held_green_r   <= '0;
    end else begin
      phase_r        <= phase_nxt;
      byte_count_r   <= byte_count_nxt;
      field_shift_r  <= field_shift_nxt;
      saved_width_r  <= saved_width_nxt;
      saved_height_r <= saved_height_nxt;
      saved_offset_r <= saved_offset_nxt;
      row_start_r    <= row_start_nxt;
      row_cnt_r      <= row_cnt_nxt;
      col_cnt_r      <= col_cnt_nxt;
      cols_r         <= cols_nxt;
      rows_r         <= rows_nxt;
      chan_r         <= chan_nxt;
      held_blue_r    <= held_blue_nxt;
      held_green_r   <= held_green_nxt;
    end
  end

endmodule

// ===== rtl/core/bhp_out_stage.sv =====
// Output register stage driving the result stream.
`timescale 1ns / 1ps
module bhp_out_stage
  import bhp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   res_valid,
  input  bhp_res_t               res,
  output logic                   up_ready,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic [1:0]             out_tuser,
  output logic                   out_tlast
);

  logic     valid_r;
  logic     valid_nxt;
  bhp_res_t res_r;

  assign up_ready   = !valid_r || out_tready;
  assign valid_nxt  = up_ready ? res_valid : valid_r;
  assign out_tvalid = valid_r;
  assign out_tuser  = res_r.status;
  assign out_tlast  = res_r.last_pixel;
  assign out_tdata  = {6'd0, res_r.pixel_offset, res_r.height, res_r.width,
                       res_r.col, res_r.row, res_r.blue, res_r.green, res_r.red};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && res_valid) begin
      res_r <= res;
    end
  end

endmodule

// ===== rtl/core/bhp_checker.sv =====
// Port-level checker for the BMP parser, bound to the top level.
`timescale 1ns / 1ps
module bhp_checker
  import bhp_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic [1:0]             out_tuser,
  input logic                   out_tlast
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid straight after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result transfer changed");

  a_pixel_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_PIXEL |-> out_tdata[OUT_TDATA_W-1:50] == '0)
    else $error("pixel result carries header fields");

  a_header_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_HEADER |-> out_tdata[49:0] == '0 && !out_tlast)
    else $error("header result carries pixel fields");

  a_error_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_FORMAT_ERR || out_tuser == ST_TRUNC)
      |-> out_tdata == '0 && !out_tlast)
    else $error("error result carries data");

endmodule

bind bmp_header_and_pixel_parser_top bhp_checker u_bhp_checker (.*);

// ===== verif/bmp_header_and_pixel_parser_top_tb.sv =====
// Testbench for the BMP header and pixel parser: byte stream in, results checked in order.
`timescale 1ns / 1ps
module bmp_header_and_pixel_parser_top_tb;
  import bhp_pkg::*;

  localparam int MAX_DIM = 8192;
  localparam int ITEMS = 950;
  localparam int LIMIT = 400000;
  localparam logic [1:0] KIND_SPARE = 2'd3;

  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_STATUS} chk_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    chk_t       chk;
    logic [1:0] status;
  } dir_row_t;

  typedef enum int {
    FL_PLAIN, FL_BAD_SIG, FL_BAD_INFO, FL_BAD_PLANES, FL_BAD_BPP, FL_BAD_COMP,
    FL_WIDE, FL_TALL, FL_LOW_OFFSET, FL_NO_ROWS, FL_NO_COLS, FL_BIG_DIM,
    FL_FAR_OFFSET, FL_CUT, FL_COUNT
  } flavour_t;

  localparam int DIR_ROWS = 22;
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    '{KIND_DATA,  8'hFF, CHK_NONE,   ST_PIXEL},
    '{KIND_DATA,  8'h00, CHK_NONE,   ST_PIXEL},
    '{KIND_END,   8'h00, CHK_NONE,   ST_PIXEL},
    '{KIND_SPARE, 8'hA5, CHK_NONE,   ST_PIXEL},
    '{KIND_START, 8'h00, CHK_NONE,   ST_PIXEL},
    '{KIND_DATA,  8'h42, CHK_MODEL,  ST_PIXEL},
    '{KIND_SPARE, 8'h5A, CHK_NONE,   ST_PIXEL},
    '{KIND_DATA,  8'h4D, CHK_MODEL,  ST_PIXEL},
    '{KIND_END,   8'h00, CHK_STATUS, ST_TRUNC},
    '{KIND_END,   8'h00, CHK_NONE,   ST_PIXEL},
    '{KIND_START, 8'hFF, CHK_NONE,   ST_PIXEL},
    '{KIND_DATA,  8'h42, CHK_MODEL,  ST_PIXEL},
    '{KIND_DATA,  8'h00, CHK_STATUS, ST_FORMAT_ERR},
    '{KIND_DATA,  8'hFF, CHK_NONE,   ST_PIXEL},
    '{KIND_END,   8'h00, CHK_NONE,   ST_PIXEL},
    '{KIND_START, 8'h00, CHK_NONE,   ST_PIXEL},
    '{KIND_START, 8'h00, CHK_NONE,   ST_PIXEL},
    '{KIND_DATA,  8'hFF, CHK_MODEL,  ST_PIXEL},
    '{KIND_DATA,  8'hFF, CHK_STATUS, ST_FORMAT_ERR},
    '{KIND_START, 8'h00, CHK_NONE,   ST_PIXEL},
    '{KIND_END,   8'h00, CHK_STATUS, ST_TRUNC},
    '{KIND_DATA,  8'h55, CHK_NONE,   ST_PIXEL}
  };

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [7:0]             in_tdata = '0;
  logic [1:0]             in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [1:0]             out_tuser;
  logic                   out_tlast;

  // parser state as seen from outside
  bhp_phase_t  ph;
  logic [31:0] nbytes, shreg, hdr_w, hdr_h, hdr_off, row_base, row_cnt, col_cnt;
  logic [1:0]  chan;
  logic [7:0]  held_b, held_g;

  bhp_res_t pending_results [$];
  bhp_res_t want_res;
  int       errors = 0;
  int       fed = 0;
  int       cycles = 0;
  bit       tx_burst = 1'b0;
  bit       rx_burst = 1'b0;
  int       stall_left = 0;
  int       rx_tick = 0;

  bmp_header_and_pixel_parser_top #(.MAX_DIM(MAX_DIM)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [31:0] magn(input logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  function automatic void clear_parse();
    ph = PH_IDLE;
    nbytes = '0; shreg = '0; hdr_w = '0; hdr_h = '0; hdr_off = '0;
    row_base = '0; row_cnt = '0; col_cnt = '0; chan = '0;
    held_b = '0; held_g = '0;
  endfunction

  function automatic void next_row();
    if (nbytes == row_base) begin
      ph = (magn(hdr_w) == 0) ? PH_DONE : PH_PIXEL;
    end else begin
      ph = PH_SKIP;
    end
  endfunction

  function automatic bit fmt_err(output bhp_res_t r);
    r = '0;
    r.status = ST_FORMAT_ERR;
    ph = PH_ERROR;
    return 1'b1;
  endfunction

  // one byte-stream transfer through the parser; returns 1 when a result is due
  function automatic bit parse_byte(input logic [1:0] k, input logic [7:0] b,
                                    output bhp_res_t r);
    logic [31:0] pos, cols, rows;
    r = '0;
    if (k == KIND_START) begin
      clear_parse();
      ph = PH_HEADER;
      return 1'b0;
    end
    if (k == KIND_END) begin
      if (ph inside {PH_HEADER, PH_SKIP, PH_PIXEL}) begin
        r.status = ST_TRUNC;
        ph = PH_IDLE;
        return 1'b1;
      end
      return 1'b0;
    end
    if (k != KIND_DATA) return 1'b0;
    cols = magn(hdr_w);
    rows = magn(hdr_h);
    case (ph)
      PH_HEADER: begin
        pos = nbytes;
        nbytes = nbytes + 32'd1;
        shreg = {b, shreg[31:8]};
        case (pos)
          POS_SIG:    if (shreg[31:16] != SIG_BM) return fmt_err(r);
          POS_OFFSET: hdr_off = shreg;
          POS_INFO:   if (shreg != INFO_SIZE) return fmt_err(r);
          POS_WIDTH:  hdr_w = shreg;
          POS_HEIGHT: hdr_h = shreg;
          POS_PLANES: if (shreg[31:16] != PLANES_ONE) return fmt_err(r);
          POS_BPP:    if (shreg[31:16] != BPP_24) return fmt_err(r);
          POS_COMP:   if (shreg != COMP_NONE) return fmt_err(r);
          POS_LAST: begin
            cols = magn(hdr_w);
            rows = magn(hdr_h);
            if (cols > MAX_DIM || rows > MAX_DIM) return fmt_err(r);
            if (rows != 0 && hdr_off < HEADER_BYTES) return fmt_err(r);
            r.status = ST_HEADER;
            r.width = hdr_w;
            r.height = hdr_h;
            r.pixel_offset = hdr_off;
            row_cnt = '0;
            col_cnt = '0;
            chan = '0;
            if (rows == 0) begin
              ph = PH_DONE;
            end else begin
              row_base = hdr_off;
              next_row();
            end
            return 1'b1;
          end
          default: ;
        endcase
        return 1'b0;
      end
      PH_SKIP: begin
        nbytes = nbytes + 32'd1;
        if (nbytes == row_base) next_row();
        return 1'b0;
      end
      PH_PIXEL: begin
        nbytes = nbytes + 32'd1;
        if (chan == 2'd0) begin
          held_b = b;
          chan = 2'd1;
          return 1'b0;
        end
        if (chan == 2'd1) begin
          held_g = b;
          chan = 2'd2;
          return 1'b0;
        end
        chan = 2'd0;
        r.status = ST_PIXEL;
        r.red = b;
        r.green = held_g;
        r.blue = held_b;
        r.row = row_cnt[ROWCOL_W-1:0];
        r.col = col_cnt[ROWCOL_W-1:0];
        r.last_pixel = (row_cnt + 32'd1 == rows) && (col_cnt + 32'd1 == cols);
        col_cnt = col_cnt + 32'd1;
        if (col_cnt >= cols) begin
          col_cnt = '0;
          row_cnt = row_cnt + 32'd1;
          if (row_cnt >= rows) begin
            ph = PH_DONE;
          end else begin
            row_base = row_base + ((cols * 32'd3 + 32'd3) & ~32'd3);
            next_row();
          end
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic int gap_len(input bit burst);
    int r;
    if (burst) return 0;
    r = $urandom_range(99, 0);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(24, 4);
  endfunction

  function automatic logic [31:0] small_dim(input int lo, input int hi);
    logic [31:0] v;
    v = $urandom_range(hi, lo);
    return $urandom_range(1, 0) ? (~v + 32'd1) : v;
  endfunction

  function automatic logic [31:0] over_dim();
    logic [31:0] v;
    case ($urandom_range(4, 0))
      0: v = 32'd8193;
      1: v = 32'hFFFF_DFFF;
      2: v = 32'h8000_0000;
      3: v = 32'h7FFF_FFFF;
      default: begin
        v = $urandom_range(32'h7FFF_FFFF, 8193);
        if ($urandom_range(1, 0)) v = ~v + 32'd1;
      end
    endcase
    return v;
  endfunction

  function automatic logic [31:0] full_dim();
    return $urandom_range(1, 0) ? 32'd8192 : 32'hFFFF_E000;
  endfunction

  task automatic send_item(input logic [1:0] k, input logic [7:0] d,
                           input chk_t chk = CHK_MODEL, input logic [1:0] st = ST_PIXEL);
    int       gap;
    bit       due;
    bhp_res_t r;
    gap = gap_len(tx_burst);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= d;
    in_tuser <= k;
    do @(posedge clk); while (!in_tready);
    fed++;
    due = parse_byte(k, d, r);
    case (chk)
      CHK_MODEL: if (due) pending_results.push_back(r);
      CHK_STATUS: begin
        r = '0;
        r.status = st;
        pending_results.push_back(r);
      end
      default: ;
    endcase
  endtask

  task automatic send_file(input flavour_t fl);
    logic [7:0]  hdr [HEADER_BYTES];
    logic [31:0] w, h, off, stride;
    longint      total, cut, len, p;
    int          i, fld_lo, fld_hi;
    w = small_dim(1, 5);
    h = small_dim(1, 3);
    off = HEADER_BYTES + $urandom_range(8, 0);
    cut = 64'h7FFF_FFFF_FFFF;
    fld_lo = -1;
    fld_hi = -1;
    case (fl)
      FL_BAD_SIG:    begin fld_lo = 0;  fld_hi = 1;  end
      FL_BAD_INFO:   begin fld_lo = 14; fld_hi = 17; end
      FL_BAD_PLANES: begin fld_lo = 26; fld_hi = 27; end
      FL_BAD_BPP:    begin fld_lo = 28; fld_hi = 29; end
      FL_BAD_COMP:   begin fld_lo = 30; fld_hi = 33; end
      FL_WIDE:       w = over_dim();
      FL_TALL:       h = over_dim();
      FL_LOW_OFFSET: off = $urandom_range(HEADER_BYTES - 1, 0);
      FL_NO_ROWS: begin
        h = '0;
        off = $urandom();
        case ($urandom_range(3, 0))
          0: w = '0;
          1: w = full_dim();
          default: ;
        endcase
      end
      FL_NO_COLS: begin
        w = '0;
        if ($urandom_range(3, 0) == 0) h = full_dim();
      end
      FL_BIG_DIM: begin
        if ($urandom_range(1, 0)) w = full_dim();
        else h = full_dim();
        cut = HEADER_BYTES + $urandom_range(60, 0);
      end
      FL_FAR_OFFSET: begin
        off = $urandom_range(1, 0) ? 32'hFFFF_FFFF : $urandom_range(32'hFFFF_FFFE, 1000);
        cut = HEADER_BYTES + $urandom_range(30, 0);
      end
      default: ;
    endcase
    // error files stop shortly after the header
    if (fl inside {FL_BAD_SIG, FL_BAD_INFO, FL_BAD_PLANES, FL_BAD_BPP, FL_BAD_COMP,
                   FL_WIDE, FL_TALL, FL_LOW_OFFSET})
      cut = HEADER_BYTES + $urandom_range(6, 0);

    for (i = 0; i < HEADER_BYTES; i++) hdr[i] = 8'($urandom);
    for (i = 0; i < 4; i++) begin
      hdr[10 + i] = off[8*i +: 8];
      hdr[14 + i] = INFO_SIZE[8*i +: 8];
      hdr[18 + i] = w[8*i +: 8];
      hdr[22 + i] = h[8*i +: 8];
      hdr[30 + i] = COMP_NONE[8*i +: 8];
      if (i < 2) begin
        hdr[i] = SIG_BM[8*i +: 8];
        hdr[26 + i] = PLANES_ONE[8*i +: 8];
        hdr[28 + i] = BPP_24[8*i +: 8];
      end
    end
    if (fld_lo >= 0) hdr[$urandom_range(fld_hi, fld_lo)] ^= 8'($urandom_range(255, 1));

    stride = (magn(w) * 32'd3 + 32'd3) & ~32'd3;
    total = (magn(h) == 0) ? longint'(HEADER_BYTES)
                           : longint'(off) + longint'(magn(h)) * longint'(stride);
    if (total < HEADER_BYTES) total = HEADER_BYTES;
    if (fl == FL_CUT) cut = $urandom_range(int'(total - 1), 0);
    len = (total < cut) ? total : cut;

    send_item(KIND_START, 8'($urandom));
    for (p = 0; p < len; p++) begin
      if ($urandom_range(40, 0) == 0) send_item(KIND_SPARE, 8'($urandom));
      send_item(KIND_DATA, (p < HEADER_BYTES) ? hdr[int'(p)] : 8'($urandom));
    end
    if (len < total) begin
      // without an end marker the next start cuts the file short
      if ($urandom_range(3, 0) != 0) send_item(KIND_END, 8'($urandom));
    end else begin
      if ($urandom_range(3, 0) == 0) begin
        repeat ($urandom_range(4, 1)) send_item(KIND_DATA, 8'($urandom));
      end
      if ($urandom_range(3, 0) == 0) send_item(KIND_END, 8'($urandom));
    end
  endtask

  task automatic check_field(input string fname, input logic [31:0] want,
                             input logic [31:0] seen);
    if (want !== seen) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, fname, want, seen);
      errors++;
    end
  endtask

  always @(negedge clk) begin
    rx_tick++;
    if (rx_tick % 300 == 0) rx_burst = ($urandom_range(3, 0) == 0);
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      stall_left = gap_len(rx_burst);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result transfer, expected none, got status %0d",
                 $time, out_tuser);
        errors++;
      end else begin
        want_res = pending_results.pop_front();
        check_field("status", want_res.status, out_tuser);
        check_field("red", want_res.red, out_tdata[7:0]);
        check_field("green", want_res.green, out_tdata[15:8]);
        check_field("blue", want_res.blue, out_tdata[23:16]);
        check_field("row", want_res.row, out_tdata[36:24]);
        check_field("col", want_res.col, out_tdata[49:37]);
        check_field("last_pixel", want_res.last_pixel, out_tlast);
        check_field("width", want_res.width, out_tdata[81:50]);
        check_field("height", want_res.height, out_tdata[113:82]);
        check_field("pixel_offset", want_res.pixel_offset, out_tdata[145:114]);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("FAIL bmp_header_and_pixel_parser_top");
      $finish;
    end
  end

  initial begin
    int i;
    int r;
    clear_parse();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < DIR_ROWS; i++)
      send_item(DIR_TAB[i].kind, DIR_TAB[i].data, DIR_TAB[i].chk, DIR_TAB[i].status);

    // hold the sender until the result stream drains
    while (pending_results.size() != 0) @(posedge clk);

    for (i = 0; i < FL_COUNT; i++) begin
      tx_burst = ($urandom_range(3, 0) == 0);
      send_file(flavour_t'(i));
    end
    while (fed < ITEMS) begin
      tx_burst = ($urandom_range(3, 0) == 0);
      r = $urandom_range(99, 0);
      if (r < 55) send_file(FL_PLAIN);
      else if (r < 70) send_file(FL_CUT);
      else send_file(flavour_t'($urandom_range(FL_COUNT - 1, 1)));
      if ($urandom_range(7, 0) == 0) begin
        while (pending_results.size() != 0) @(posedge clk);
      end
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("PASS bmp_header_and_pixel_parser_top");
    end else begin
      $display("FAIL bmp_header_and_pixel_parser_top");
    end
    $finish;
  end

endmodule
